// File: hdl/anf_pkg.sv
`default_nettype none

package anf_pkg;

   localparam int DATA_WIDTH  = 32;
   localparam int SHAMT_WIDTH = $clog2(DATA_WIDTH);

   localparam int FUNC_WIDTH = 3;
   localparam int COND_WIDTH = 3;

   // req tdata: operand_a, operand_b, set_flags, cond_code, zero fill to bytes
   localparam int REQ_BITS       = 2 * DATA_WIDTH + 1 + COND_WIDTH;
   localparam int REQ_DATA_WIDTH = ((REQ_BITS + 7) / 8) * 8;
   // rsp tdata: result, cond_passed, flag_n, flag_z, flag_c, flag_v
   localparam int RSP_BITS       = DATA_WIDTH + 5;
   localparam int RSP_DATA_WIDTH = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [FUNC_WIDTH-1:0] {
      FUNC_ADD  = 3'd0,
      FUNC_SUB  = 3'd1,
      FUNC_AND  = 3'd2,
      FUNC_OR   = 3'd3,
      FUNC_XOR  = 3'd4,
      FUNC_SHL  = 3'd5,
      FUNC_SHR  = 3'd6,
      FUNC_ZERO = 3'd7
   } func_type;

   typedef enum logic [COND_WIDTH-1:0] {
      COND_AL = 3'd0,
      COND_EQ = 3'd1,
      COND_NE = 3'd2,
      COND_GT = 3'd3,
      COND_LT = 3'd4,
      COND_GE = 3'd5,
      COND_LE = 3'd6,
      COND_NV = 3'd7
   } cond_type;

   typedef struct packed {
      logic n;
      logic z;
      logic c;
      logic v;
   } flags_type;

endpackage

`default_nettype wire

// File: hdl/anf_exec.sv
`default_nettype none

module anf_exec (
   input  wire logic [anf_pkg::FUNC_WIDTH-1:0] func,
   input  wire logic [anf_pkg::DATA_WIDTH-1:0] operand_a,
   input  wire logic [anf_pkg::DATA_WIDTH-1:0] operand_b,
   output logic      [anf_pkg::DATA_WIDTH-1:0] result,
   output anf_pkg::flags_type                  flags
);

   localparam int DW = anf_pkg::DATA_WIDTH;
   localparam int SW = anf_pkg::SHAMT_WIDTH;

   logic [DW:0]   sum;
   logic [DW:0]   diff;
   logic          shamt_big;
   logic [SW-1:0] shamt;

   assign sum       = {1'b0, operand_a} + {1'b0, operand_b};
   assign diff      = {1'b0, operand_a} - {1'b0, operand_b};
   assign shamt     = operand_b[SW-1:0];
   assign shamt_big = |operand_b[DW-1:SW];

   always_comb begin
      case (anf_pkg::func_type'(func))
         anf_pkg::FUNC_ADD: result = sum[DW-1:0];
         anf_pkg::FUNC_SUB: result = diff[DW-1:0];
         anf_pkg::FUNC_AND: result = operand_a & operand_b;
         anf_pkg::FUNC_OR:  result = operand_a | operand_b;
         anf_pkg::FUNC_XOR: result = operand_a ^ operand_b;
         anf_pkg::FUNC_SHL: result = shamt_big ? '0 : (operand_a << shamt);
         anf_pkg::FUNC_SHR: result = shamt_big ? '0 : (operand_a >> shamt);
         default:           result = '0;
      endcase
   end

   always_comb begin
      flags.n = result[DW-1];
      flags.z = (result == '0);
      if (anf_pkg::func_type'(func) == anf_pkg::FUNC_SUB) begin
         // no borrow
         flags.c = ~diff[DW];
         flags.v = (operand_a[DW-1] ^ operand_b[DW-1]) & (operand_a[DW-1] ^ diff[DW-1]);
      end else begin
         // all other ops report the add carry and overflow
         flags.c = sum[DW];
         flags.v = ~(operand_a[DW-1] ^ operand_b[DW-1]) & (operand_a[DW-1] ^ sum[DW-1]);
      end
   end

endmodule

`default_nettype wire

// File: hdl/anf_flag_reg.sv
`default_nettype none

module anf_flag_reg (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           update,
   input  wire anf_pkg::flags_type             flags_new,
   input  wire logic [anf_pkg::COND_WIDTH-1:0] cond_code,
   output anf_pkg::flags_type                  flags_next,
   output anf_pkg::flags_type                  flags_cur,
   output logic                                cond_passed
);

   anf_pkg::flags_type flags_ff;
   anf_pkg::flags_type flags_in;

   assign flags_in   = update ? flags_new : flags_ff;
   assign flags_next = flags_in;
   assign flags_cur  = flags_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   // condition test on flags held before the beat
   always_comb begin
      case (anf_pkg::cond_type'(cond_code))
         anf_pkg::COND_AL: cond_passed = 1'b1;
         anf_pkg::COND_EQ: cond_passed = flags_ff.z;
         anf_pkg::COND_NE: cond_passed = ~flags_ff.z;
         anf_pkg::COND_GT: cond_passed = ~flags_ff.z & (flags_ff.n == flags_ff.v);
         anf_pkg::COND_LT: cond_passed = flags_ff.n != flags_ff.v;
         anf_pkg::COND_GE: cond_passed = flags_ff.n == flags_ff.v;
         anf_pkg::COND_LE: cond_passed = flags_ff.z | (flags_ff.n != flags_ff.v);
         default:          cond_passed = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

// File: hdl/alu_with_nzcv_flags.sv
// alu with nzcv flags
// path: a req beat passes the input register, then the result register, to become the rsp beat
// throughput: one beat per cycle; req_tready stays high while the result register drains
// or is empty, so a full pipeline only stalls when rsp_tready is low
// reset: synchronous, active high; clears both valid bits and the stored flags to zero
`default_nettype none

module alu_with_nzcv_flags (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // operand_a, operand_b, set_flags, cond_code, zero fill
   input  wire logic [anf_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   // func
   input  wire logic [anf_pkg::FUNC_WIDTH-1:0]     req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // result, cond_passed, flag_n, flag_z, flag_c, flag_v, zero fill
   output logic      [anf_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);

   localparam int DW = anf_pkg::DATA_WIDTH;
   localparam int CW = anf_pkg::COND_WIDTH;

   // input register stage
   logic                                v1_ff, v1_in;
   logic [anf_pkg::FUNC_WIDTH-1:0]      func_ff;
   logic [DW-1:0]                       opa_ff;
   logic [DW-1:0]                       opb_ff;
   logic                                setf_ff;
   logic [CW-1:0]                       cond_ff;

   // result register stage
   logic                                v2_ff, v2_in;
   logic [DW-1:0]                       res_ff;
   logic                                pass_ff;
   anf_pkg::flags_type                  oflags_ff;

   logic                                req_fire;
   logic                                adv2;
   logic                                load2;
   logic [DW-1:0]                       ex_result;
   anf_pkg::flags_type                  ex_flags;
   anf_pkg::flags_type                  flags_next;
   anf_pkg::flags_type                  flags_cur;
   logic                                cond_passed;

   // result register can take a new beat when empty or being drained
   assign adv2       = ~v2_ff | rsp_tready;
   assign load2      = v1_ff & adv2;
   assign req_tready = ~v1_ff | adv2;
   assign req_fire   = req_tvalid & req_tready;

   assign v1_in = req_fire | (v1_ff & ~adv2);
   assign v2_in = load2 | (v2_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   // payload of the input stage
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff <= req_tuser;
         opa_ff  <= req_tdata[DW-1:0];
         opb_ff  <= req_tdata[2*DW-1:DW];
         setf_ff <= req_tdata[2*DW];
         cond_ff <= req_tdata[2*DW+CW:2*DW+1];
      end
   end

   anf_exec u_exec (
      .func      (func_ff),
      .operand_a (opa_ff),
      .operand_b (opb_ff),
      .result    (ex_result),
      .flags     (ex_flags)
   );

   // flags change only when a beat moves into the result register
   anf_flag_reg u_flag_reg (
      .clock       (clock),
      .reset       (reset),
      .update      (load2 & setf_ff),
      .flags_new   (ex_flags),
      .cond_code   (cond_ff),
      .flags_next  (flags_next),
      .flags_cur   (flags_cur),
      .cond_passed (cond_passed)
   );

   always_ff @(posedge clock) begin
      if (load2) begin
         res_ff    <= ex_result;
         pass_ff   <= cond_passed;
         oflags_ff <= flags_next;
      end
   end

   assign rsp_tvalid = v2_ff;
   assign rsp_tdata  = {{(anf_pkg::RSP_DATA_WIDTH - anf_pkg::RSP_BITS){1'b0}},
                        oflags_ff.v, oflags_ff.c, oflags_ff.z, oflags_ff.n,
                        pass_ff, res_ff};

   // stored flags only move when a beat enters the result register
   assert property (@(posedge clock) disable iff (reset)
      !load2 |=> $stable(flags_cur))
      else $error("flags changed without a beat");

   // reported flags match the stored flags right after the load
   assert property (@(posedge clock) disable iff (reset)
      load2 |=> (oflags_ff == flags_cur))
      else $error("reported flags differ from stored flags");

   // a never condition cannot pass
   assert property (@(posedge clock) disable iff (reset)
      (load2 && (cond_ff == anf_pkg::COND_NV)) |=> !pass_ff)
      else $error("never condition passed");

   // an empty input stage always accepts
   assert property (@(posedge clock) disable iff (reset)
      !v1_ff |-> req_tready)
      else $error("empty pipeline stalled input");

endmodule

`default_nettype wire
